### src/integer_printf_formatter_macros.svh
// ----------------------------------------------------------------------------
// Integer printf formatter assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef INTEGER_PRINTF_FORMATTER_MACROS_SVH
`define INTEGER_PRINTF_FORMATTER_MACROS_SVH
`ifndef SYNTH
`define IPF_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("ipf assertion failed");
`define IPF_ASSERT_NXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("ipf assertion failed");
`else
`define IPF_ASSERT_IMP(label, a, c)
`define IPF_ASSERT_NXT(label, a, c)
`endif
`endif

### src/ipf_pkg.sv
// ----------------------------------------------------------------------------
// Integer printf formatter package
// Shared constants, segment codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ipf_pkg;

  localparam int MAX_FIELD_DEF = 64;
  localparam int MAX_DIGITS    = 20;
  localparam int DIG_BITS      = 4 * MAX_DIGITS;
  localparam int NDW           = 5;
  localparam int CONV_STEPS    = 32;
  localparam int CSW           = 5;

  typedef enum logic [2:0] {
    CONV_SDEC,
    CONV_UDEC,
    CONV_HEX_LO,
    CONV_HEX_UP,
    CONV_PTR,
    CONV_SPARE5,
    CONV_SPARE6,
    CONV_SPARE7
  } conv_t;

  typedef enum logic [2:0] {
    SEG_LEAD,
    SEG_PRE,
    SEG_ZERO,
    SEG_DIG,
    SEG_TRAIL
  } seg_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic meas;
    logic setup;
    logic emit;
    logic empty;
    logic seg_load;
    seg_t load_seg;
    seg_t cur_seg;
    logic last;
  } ipf_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic nz_lead;
    logic nz_pre;
    logic nz_zero;
    logic nz_dig;
    logic nz_trail;
    logic cnt_one;
  } ipf_stat_t;

endpackage

`default_nettype wire

### src/ipf_ctrl.sv
// ----------------------------------------------------------------------------
// Integer printf formatter controller
// Sequences conversion, sizing and the emission of the field segments.
// ----------------------------------------------------------------------------
`default_nettype none

module ipf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ipf_pkg::ipf_stat_t  sts,
  output logic                busy,
  output ipf_pkg::ipf_cmd_t   ctl
);
  import ipf_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CONV  = 11'b00000000010,
    S_MEAS  = 11'b00000000100,
    S_SETUP = 11'b00000001000,
    S_PLAN  = 11'b00000010000,
    S_LEAD  = 11'b00000100000,
    S_PRE   = 11'b00001000000,
    S_ZERO  = 11'b00010000000,
    S_DIG   = 11'b00100000000,
    S_TRAIL = 11'b01000000000,
    S_EMPTY = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;
  state_t follow;

  function automatic logic is_seg(input state_t s);
    return (s == S_LEAD) || (s == S_PRE) || (s == S_ZERO) || (s == S_DIG) ||
           (s == S_TRAIL);
  endfunction

  function automatic seg_t seg_of(input state_t s);
    seg_t r;
    unique case (s)
      S_PRE:   r = SEG_PRE;
      S_ZERO:  r = SEG_ZERO;
      S_DIG:   r = SEG_DIG;
      S_TRAIL: r = SEG_TRAIL;
      default: r = SEG_LEAD;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pick the first non-empty segment after the current one
  always_comb begin
    follow = S_IDLE;
    unique case (state)
      S_PLAN: begin
        priority if (sts.nz_lead) follow = S_LEAD;
        else if (sts.nz_pre)      follow = S_PRE;
        else if (sts.nz_zero)     follow = S_ZERO;
        else if (sts.nz_dig)      follow = S_DIG;
        else if (sts.nz_trail)    follow = S_TRAIL;
        else                      follow = S_EMPTY;
      end
      S_LEAD: begin
        priority if (sts.nz_pre) follow = S_PRE;
        else if (sts.nz_zero)    follow = S_ZERO;
        else if (sts.nz_dig)     follow = S_DIG;
        else if (sts.nz_trail)   follow = S_TRAIL;
        else                     follow = S_IDLE;
      end
      S_PRE: begin
        priority if (sts.nz_zero) follow = S_ZERO;
        else if (sts.nz_dig)      follow = S_DIG;
        else if (sts.nz_trail)    follow = S_TRAIL;
        else                      follow = S_IDLE;
      end
      S_ZERO: begin
        priority if (sts.nz_dig) follow = S_DIG;
        else if (sts.nz_trail)   follow = S_TRAIL;
        else                     follow = S_IDLE;
      end
      S_DIG: begin
        priority if (sts.nz_trail) follow = S_TRAIL;
        else                       follow = S_IDLE;
      end
      default: follow = S_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      S_IDLE:  state_next = start ? S_CONV : S_IDLE;
      S_CONV:  state_next = sts.conv_done ? S_MEAS : S_CONV;
      S_MEAS:  state_next = S_SETUP;
      S_SETUP: state_next = S_PLAN;
      S_PLAN:  state_next = follow;
      S_LEAD, S_PRE, S_ZERO, S_DIG, S_TRAIL: begin
        state_next = sts.cnt_one ? follow : state;
      end
      S_EMPTY: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.load     = (state == S_IDLE) && start;
    ctl.conv     = (state == S_CONV);
    ctl.meas     = (state == S_MEAS);
    ctl.setup    = (state == S_SETUP);
    ctl.emit     = is_seg(state);
    ctl.empty    = (state == S_EMPTY);
    ctl.seg_load = is_seg(state_next) && (state_next != state);
    ctl.load_seg = seg_of(state_next);
    ctl.cur_seg  = seg_of(state);
    ctl.last     = ctl.empty || (ctl.emit && sts.cnt_one && (follow == S_IDLE));
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

### src/ipf_dp.sv
// ----------------------------------------------------------------------------
// Integer printf formatter datapath
// Holds the request, converts to BCD, sizes the segments and forms characters.
// ----------------------------------------------------------------------------
`default_nettype none

module ipf_dp #(
  parameter int MAX_FIELD = ipf_pkg::MAX_FIELD_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [2:0]         cmd,
  input  logic signed [63:0] value,
  input  logic [6:0]         field_width,
  input  logic signed [6:0]  precision,
  input  logic               zero_pad,
  input  logic               left_justify,
  input  logic               alt_form,
  input  logic               plus_sign,
  input  logic               space_sign,
  input  ipf_pkg::ipf_cmd_t  ctl,
  output ipf_pkg::ipf_stat_t sts,
  output logic               strobe,
  output logic [7:0]         out_char,
  output logic               char_valid,
  output logic               last,
  output logic [6:0]         total_length
);
  import ipf_pkg::*;

  localparam int LW = ($clog2(MAX_FIELD + 1) > 7) ? $clog2(MAX_FIELD + 1) : 7;
  localparam logic [LW-1:0] FIELD_MAX = LW'(MAX_FIELD);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UA10  = 8'h37;
  localparam logic [7:0] CH_LA10  = 8'h57;

  function automatic logic [DIG_BITS-1:0] dd_step(input logic [DIG_BITS-1:0] b,
                                                  input logic bit_in);
    logic [DIG_BITS-1:0] a;
    a = b;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (a[4*i +: 4] >= 4'd5) a[4*i +: 4] = a[4*i +: 4] + 4'd3;
    end
    return {a[DIG_BITS-2:0], bit_in};
  endfunction

  // request decode
  logic [63:0]   raw;
  logic          is_hex_in;
  logic          is_signed_in;
  logic [63:0]   mag_in;
  logic [1:0]    np_in;
  logic [7:0]    p0_in;
  logic [7:0]    p1_in;
  logic [LW-1:0] prec_raw_in;
  logic [LW-1:0] lim_in;
  logic [LW-1:0] prec_c_in;
  logic [LW-1:0] width_ext;
  logic [LW-1:0] width_c_in;

  // held request and working state
  logic [63:0]         sh;
  logic [DIG_BITS-1:0] dig;
  logic [CSW-1:0]      conv_cnt;
  logic                dec;
  logic                upper;
  logic [1:0]          np;
  logic [7:0]          p0;
  logic [7:0]          p1;
  logic [LW-1:0]       prec_c;
  logic [LW-1:0]       width_c;
  logic                zpad;
  logic                left;
  logic [NDW-1:0]      nd;
  logic [LW-1:0]       dzero;
  logic [LW-1:0]       body;
  logic [LW-1:0]       len_lead;
  logic [LW-1:0]       len_zero;
  logic [LW-1:0]       len_trail;
  logic [LW-1:0]       total;
  logic [LW-1:0]       cnt;
  logic [NDW-1:0]      dptr;

  logic [NDW-1:0] nd_c;
  logic [LW-1:0]  nd_c_ext;
  logic [LW-1:0]  nd_ext;
  logic [LW-1:0]  pad_c;
  logic [3:0]     nib;
  logic [7:0]     dch;
  logic [7:0]     ch;

  always_comb begin
    raw          = value;
    is_hex_in    = (cmd == CONV_HEX_LO) || (cmd == CONV_HEX_UP) || (cmd == CONV_PTR);
    is_signed_in = !((cmd == CONV_UDEC) || is_hex_in);
    mag_in       = (is_signed_in && raw[63]) ? (64'd0 - raw) : raw;
    np_in        = 2'd0;
    p0_in        = CH_ZERO;
    p1_in        = CH_LX;
    priority if ((((cmd == CONV_HEX_LO) || (cmd == CONV_HEX_UP)) && alt_form && (|raw)) ||
                 (cmd == CONV_PTR)) begin
      np_in = 2'd2;
      p1_in = (cmd == CONV_HEX_UP) ? CH_UX : CH_LX;
    end else if (is_signed_in && raw[63]) begin
      np_in = 2'd1;
      p0_in = CH_MINUS;
    end else if (is_signed_in && plus_sign) begin
      np_in = 2'd1;
      p0_in = CH_PLUS;
    end else if (is_signed_in && space_sign) begin
      np_in = 2'd1;
      p0_in = CH_SPACE;
    end else begin
      np_in = 2'd0;
    end
    prec_raw_in = precision[6] ? LW'(1) : LW'(precision[5:0]);
    lim_in      = FIELD_MAX - LW'(np_in);
    prec_c_in   = (prec_raw_in > lim_in) ? lim_in : prec_raw_in;
    width_ext   = LW'(field_width);
    width_c_in  = (width_ext > FIELD_MAX) ? FIELD_MAX : width_ext;
  end

  always_comb begin
    nd_c = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (dig[4*i +: 4] != 4'd0) nd_c = NDW'(i + 1);
    end
    nd_c_ext = LW'(nd_c);
    nd_ext   = LW'(nd);
    pad_c    = (width_c > body) ? (width_c - body) : '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sh       <= mag_in;
      dig      <= is_hex_in ? DIG_BITS'(raw) : '0;
      conv_cnt <= '0;
      dec      <= !is_hex_in;
      upper    <= (cmd == CONV_HEX_UP);
      np       <= np_in;
      p0       <= p0_in;
      p1       <= p1_in;
      prec_c   <= prec_c_in;
      width_c  <= width_c_in;
      zpad     <= zero_pad;
      left     <= left_justify;
    end else if (ctl.conv && dec) begin
      sh       <= {sh[61:0], 2'b00};
      dig      <= dd_step(dd_step(dig, sh[63]), sh[62]);
      conv_cnt <= conv_cnt + CSW'(1);
    end
  end

  // size the body from the digit count at MEAS; segment lengths follow at SETUP
  always_ff @(posedge clk) begin
    if (ctl.meas) begin
      nd    <= nd_c;
      dzero <= (prec_c > nd_c_ext) ? (prec_c - nd_c_ext) : '0;
      body  <= ((prec_c > nd_c_ext) ? prec_c : nd_c_ext) + LW'(np);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.setup) begin
      len_lead  <= (!left && !zpad) ? pad_c : '0;
      len_zero  <= dzero + ((!left && zpad) ? pad_c : '0);
      len_trail <= left ? pad_c : '0;
      total     <= body + pad_c;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.seg_load) begin
      unique case (ctl.load_seg)
        SEG_LEAD:  cnt <= len_lead;
        SEG_PRE:   cnt <= LW'(np);
        SEG_ZERO:  cnt <= len_zero;
        SEG_DIG:   cnt <= nd_ext;
        SEG_TRAIL: cnt <= len_trail;
        default:   cnt <= '0;
      endcase
      dptr <= nd - NDW'(1);
    end else if (ctl.emit) begin
      cnt <= cnt - LW'(1);
      if (ctl.cur_seg == SEG_DIG) dptr <= dptr - NDW'(1);
    end
  end

  always_comb begin
    sts.conv_done = !dec || (conv_cnt == CSW'(CONV_STEPS - 1));
    sts.nz_lead   = (len_lead != '0);
    sts.nz_pre    = (np != 2'd0);
    sts.nz_zero   = (len_zero != '0);
    sts.nz_dig    = (nd != '0);
    sts.nz_trail  = (len_trail != '0);
    sts.cnt_one   = (cnt == LW'(1));
  end

  always_comb begin
    nib = dig[{dptr, 2'b00} +: 4];
    dch = (nib < 4'd10) ? (CH_ZERO + {4'b0000, nib})
                        : ((upper ? CH_UA10 : CH_LA10) + {4'b0000, nib});
    unique case (ctl.cur_seg)
      SEG_LEAD:  ch = CH_SPACE;
      SEG_PRE:   ch = ((np == 2'd2) && (cnt == LW'(1))) ? p1 : p0;
      SEG_ZERO:  ch = CH_ZERO;
      SEG_DIG:   ch = dch;
      SEG_TRAIL: ch = CH_SPACE;
      default:   ch = CH_NUL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe     <= 1'b0;
      char_valid <= 1'b0;
      last       <= 1'b0;
    end else begin
      strobe     <= ctl.emit || ctl.empty;
      char_valid <= ctl.emit;
      last       <= ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    out_char     <= ctl.emit ? ch : CH_NUL;
    total_length <= ctl.empty ? 7'd0 : total[6:0];
  end

endmodule

`default_nettype wire

### src/integer_printf_formatter.sv
// ----------------------------------------------------------------------------
// Integer printf formatter
// Formats a 64-bit value as %d %u %x %X or %p, one ASCII character per cycle.
// Decimal values are converted to BCD in 32 two-bit shift-add steps; hex and
// pointer values are loaded straight into the digit register.
// The characters then follow one per cycle; busy stays high while a request
// is converted, sized and emitted.
// Reset: synchronous rst returns the controller to idle and drops strobe.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_printf_formatter_macros.svh"

module integer_printf_formatter #(
  parameter int MAX_FIELD = ipf_pkg::MAX_FIELD_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         cmd,
  input  logic signed [63:0] value,
  input  logic [6:0]         field_width,
  input  logic signed [6:0]  precision,
  input  logic               zero_pad,
  input  logic               left_justify,
  input  logic               alt_form,
  input  logic               plus_sign,
  input  logic               space_sign,
  output logic               strobe,
  output logic [7:0]         out_char,
  output logic               char_valid,
  output logic               last,
  output logic [6:0]         total_length
);
  import ipf_pkg::*;

  ipf_cmd_t  ctl;
  ipf_stat_t sts;

  ipf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .ctl   (ctl)
  );

  ipf_dp #(
    .MAX_FIELD (MAX_FIELD)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (value),
    .field_width  (field_width),
    .precision    (precision),
    .zero_pad     (zero_pad),
    .left_justify (left_justify),
    .alt_form     (alt_form),
    .plus_sign    (plus_sign),
    .space_sign   (space_sign),
    .ctl          (ctl),
    .sts          (sts),
    .strobe       (strobe),
    .out_char     (out_char),
    .char_valid   (char_valid),
    .last         (last),
    .total_length (total_length)
  );

  `IPF_ASSERT_IMP(a_empty_item, strobe && !char_valid, last && (total_length == 7'd0))
  `IPF_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `IPF_ASSERT_NXT(a_last_gap, strobe && last, !strobe)
  `IPF_ASSERT_IMP(a_emit_busy, ctl.emit, busy)

endmodule

`default_nettype wire
